// File: src/b32u_pkg.sv
// Shared types, constants and helper functions for the base32 to UUID text block.
// No dependencies; every other file in src/ refers to this package by scoped name.
`default_nettype none

package b32u_pkg;

  localparam int unsigned IdBytes  = 16;
  localparam int unsigned AddrW    = $clog2(IdBytes);
  localparam int unsigned FillW    = AddrW + 1;
  localparam int unsigned TextLen  = 36;
  localparam int unsigned PosW     = $clog2(TextLen);
  localparam logic [PosW-1:0] LastPos = PosW'(TextLen - 1);

  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChSeven = 8'h37;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       ok;
    logic       last_out;
  } out_beat_t;

  // emitter -> packer
  typedef struct packed {
    logic flush;
    logic clear;
  } pack_ctl_t;

  // packer -> emitter
  typedef struct packed {
    logic             bad;
    logic             any;
    logic [FillW-1:0] fill;
  } pack_stat_t;

  typedef struct packed {
    logic             dash;
    logic [AddrW-1:0] idx;
    logic             hi;
  } pos_info_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] value;
  } sym_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_PREP,
    ST_LOAD,
    ST_SHOW
  } emit_state_e;

  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t s;
    s.valid = 1'b0;
    s.value = 5'd0;
    if (c >= ChLowA && c <= ChLowZ) begin
      s.valid = 1'b1;
      s.value = 5'(c - ChLowA);
    end else if (c >= ChTwo && c <= ChSeven) begin
      s.valid = 1'b1;
      s.value = 5'(c - ChTwo) + 5'd26;
    end
    return s;
  endfunction

  // 8-4-4-4-12 layout: dashes at text positions 8, 13, 18 and 23
  function automatic pos_info_t pos_info(input logic [PosW-1:0] pos);
    pos_info_t  r;
    logic [PosW-1:0] p;
    r.dash = 1'b0;
    r.idx  = '0;
    r.hi   = 1'b0;
    p      = '0;
    if (pos < PosW'(8)) begin
      p     = pos;
      r.idx = AddrW'(p >> 1);
    end else if (pos == PosW'(8) || pos == PosW'(13) || pos == PosW'(18)
                 || pos == PosW'(23)) begin
      r.dash = 1'b1;
    end else if (pos < PosW'(13)) begin
      p     = pos - PosW'(9);
      r.idx = AddrW'(p >> 1) + AddrW'(4);
    end else if (pos < PosW'(18)) begin
      p     = pos - PosW'(14);
      r.idx = AddrW'(p >> 1) + AddrW'(6);
    end else if (pos < PosW'(23)) begin
      p     = pos - PosW'(19);
      r.idx = AddrW'(p >> 1) + AddrW'(8);
    end else begin
      p     = pos - PosW'(24);
      r.idx = AddrW'(p >> 1) + AddrW'(10);
    end
    r.hi = ~p[0];
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = ChZero + 8'(n);
    end else begin
      c = ChLowA + 8'(n - 4'd10);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/b32u_ram.sv
// Byte store: 16 x 8 synchronous memory, one write port, one registered read port.
// Depends on b32u_pkg for the depth and address width.
`default_nettype none

module b32u_ram (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [b32u_pkg::AddrW-1:0] wr_addr_i,
  input  wire logic [7:0]                wr_data_i,
  input  wire logic [b32u_pkg::AddrW-1:0] rd_addr_i,
  output logic      [7:0]                rd_data_o
);

  logic [7:0] mem [b32u_pkg::IdBytes];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: src/b32u_pack.sv
// Symbol decode and bit packer: folds 5-bit symbols into bytes and writes them
// to the byte store. Depends on b32u_pkg.
`default_nettype none

module b32u_pack (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       take_i,
  input  wire b32u_pkg::in_beat_t         beat_i,
  input  wire b32u_pkg::pack_ctl_t        ctl_i,
  output b32u_pkg::pack_stat_t            stat_o,
  output logic                            wr_en_o,
  output logic [b32u_pkg::AddrW-1:0]      wr_addr_o,
  output logic [7:0]                      wr_data_o
);

  logic [6:0]                  acc_q, acc_d;
  logic [2:0]                  pend_q, pend_d;
  logic [b32u_pkg::FillW-1:0]  fill_q, fill_d;
  logic                        bad_q, bad_d;
  logic                        any_q, any_d;

  b32u_pkg::sym_t sym;
  logic [11:0]    acc_wide;
  logic [3:0]     pend_sum;
  logic [2:0]     rem;
  logic [11:0]    rem_mask;
  logic [7:0]     flush_byte;
  logic [3:0]     flush_sh;
  logic           has_room;

  assign sym      = b32u_pkg::sym_decode(beat_i.char_code);
  assign acc_wide = {acc_q, sym.value};
  assign pend_sum = {1'b0, pend_q} + 4'd5;
  assign rem      = pend_sum[2:0];
  assign rem_mask = (12'd1 << rem) - 12'd1;
  assign flush_sh = 4'd8 - {1'b0, pend_q};
  assign flush_byte = 8'({1'b0, acc_q} << flush_sh);
  assign has_room = ~fill_q[b32u_pkg::FillW-1];

  always_comb begin
    acc_d     = acc_q;
    pend_d    = pend_q;
    fill_d    = fill_q;
    bad_d     = bad_q;
    any_d     = any_q;
    wr_en_o   = 1'b0;
    wr_addr_o = fill_q[b32u_pkg::AddrW-1:0];
    wr_data_o = flush_byte;

    if (ctl_i.clear) begin
      acc_d  = '0;
      pend_d = '0;
      fill_d = '0;
      bad_d  = 1'b0;
      any_d  = 1'b0;
    end else if (ctl_i.flush) begin
      // trailing partial byte, zero padded on the right
      if (pend_q != 3'd0 && has_room) begin
        wr_en_o = 1'b1;
        fill_d  = fill_q + b32u_pkg::FillW'(1);
      end
    end else if (take_i && beat_i.has_char) begin
      any_d = 1'b1;
      if (!sym.valid) begin
        bad_d = 1'b1;
      end else begin
        pend_d = rem;
        if (pend_sum[3]) begin
          wr_data_o = 8'(acc_wide >> rem);
          acc_d     = 7'(acc_wide & rem_mask);
          if (has_room) begin
            wr_en_o = 1'b1;
            fill_d  = fill_q + b32u_pkg::FillW'(1);
          end
        end else begin
          acc_d = 7'(acc_wide);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
      fill_q <= '0;
      bad_q  <= 1'b0;
      any_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
      fill_q <= fill_d;
      bad_q  <= bad_d;
      any_q  <= any_d;
    end
  end

  assign stat_o.bad  = bad_q;
  assign stat_o.any  = any_q;
  assign stat_o.fill = fill_q;

endmodule

`default_nettype wire

// File: src/b32u_emit.sv
// Emit sequencer: walks the 36 text positions, reads the byte store and drives
// the output register. Depends on b32u_pkg.
`default_nettype none

module b32u_emit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire b32u_pkg::pack_stat_t       stat_i,
  output b32u_pkg::pack_ctl_t             ctl_o,
  output logic [b32u_pkg::AddrW-1:0]      rd_addr_o,
  input  wire logic [7:0]                 rd_data_i,
  output logic                            idle_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output b32u_pkg::out_beat_t             out_data_o
);

  b32u_pkg::emit_state_e          state_q, state_d;
  logic [b32u_pkg::PosW-1:0]      pos_q, pos_d;
  logic                           valid_q, valid_d;
  b32u_pkg::out_beat_t            out_q, out_d;

  b32u_pkg::pos_info_t cur_info;
  b32u_pkg::pos_info_t nxt_info;
  logic [7:0]          byte_val;
  logic                beat_done;

  assign cur_info  = b32u_pkg::pos_info(pos_q);
  assign nxt_info  = b32u_pkg::pos_info(pos_d);
  // read address follows the next position so data lands in ST_LOAD
  assign rd_addr_o = nxt_info.idx;
  // entries at or past the fill count were never written this string: zero
  assign byte_val  = ({1'b0, cur_info.idx} < stat_i.fill) ? rd_data_i : 8'h00;
  assign beat_done = valid_q & out_ready_i;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    valid_d     = valid_q;
    out_d       = out_q;
    ctl_o.flush = 1'b0;
    ctl_o.clear = 1'b0;

    unique case (state_q)
      b32u_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = b32u_pkg::ST_FLUSH;
        end
      end
      b32u_pkg::ST_FLUSH: begin
        pos_d = '0;
        if (stat_i.bad || !stat_i.any) begin
          out_d.text_char = 8'h00;
          out_d.ok        = 1'b0;
          out_d.last_out  = 1'b1;
          valid_d         = 1'b1;
          state_d         = b32u_pkg::ST_SHOW;
        end else begin
          ctl_o.flush = 1'b1;
          state_d     = b32u_pkg::ST_PREP;
        end
      end
      b32u_pkg::ST_PREP: begin
        state_d = b32u_pkg::ST_LOAD;
      end
      b32u_pkg::ST_LOAD: begin
        out_d.text_char = cur_info.dash ? b32u_pkg::ChDash :
                          b32u_pkg::hex_char(cur_info.hi ? byte_val[7:4] : byte_val[3:0]);
        out_d.ok        = 1'b1;
        out_d.last_out  = (pos_q == b32u_pkg::LastPos);
        valid_d         = 1'b1;
        state_d         = b32u_pkg::ST_SHOW;
      end
      b32u_pkg::ST_SHOW: begin
        if (beat_done) begin
          valid_d = 1'b0;
          if (out_q.last_out) begin
            ctl_o.clear = 1'b1;
            pos_d       = '0;
            state_d     = b32u_pkg::ST_IDLE;
          end else begin
            pos_d   = pos_q + b32u_pkg::PosW'(1);
            state_d = b32u_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = b32u_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b32u_pkg::ST_IDLE;
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign idle_o      = (state_q == b32u_pkg::ST_IDLE);
  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: src/base32_to_uuid_text.sv
// base32_to_uuid_text: decodes a lower-case base32 string into 16 bytes and
// emits them as 36 characters of UUID text (8-4-4-4-12, lowercase hex).
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one character per beat;
// has_char = 0 marks a beat with no character, last_in ends the string. While
// a string is being taken in, a beat is accepted every cycle.
// After a beat with last_in the input stalls (in_ready_o low) until the whole
// answer has been taken. The answer is either 36 text beats (ok = 1, last_out
// on the final one) or a single failure beat (text_char = 0, ok = 0,
// last_out = 1) for an invalid character or an empty string.
// The last input beat leads to ST_FLUSH and then ST_PREP; each text beat is
// built in ST_LOAD (one byte store read per beat plus the output register) and
// held in ST_SHOW until taken, so out_valid_o drops between text beats. A
// failure beat is set up in ST_FLUSH and goes straight to ST_SHOW.
// A receiver stall simply holds the output register; nothing is lost.
// Reset returns to idle with an empty string; the byte store needs no clearing
// since bytes past the fill count read as zero.
`default_nettype none

module base32_to_uuid_text (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire b32u_pkg::in_beat_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output b32u_pkg::out_beat_t       out_data_o
);

  b32u_pkg::pack_ctl_t           ctl;
  b32u_pkg::pack_stat_t          stat;
  logic                          idle;
  logic                          take;
  logic                          wr_en;
  logic [b32u_pkg::AddrW-1:0]    wr_addr;
  logic [7:0]                    wr_data;
  logic [b32u_pkg::AddrW-1:0]    rd_addr;
  logic [7:0]                    rd_data;

  assign in_ready_o = idle;
  assign take       = in_valid_i & idle;

  b32u_pack u_pack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .beat_i    (in_data_i),
    .ctl_i     (ctl),
    .stat_o    (stat),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  b32u_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  b32u_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (take & in_data_i.last_in),
    .stat_i      (stat),
    .ctl_o       (ctl),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .idle_o      (idle),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: src/b32u_check.sv
// Port-level checker for base32_to_uuid_text, attached by the bind below.
// Depends on b32u_pkg for the beat types.
`default_nettype none

module b32u_check (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire b32u_pkg::in_beat_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire b32u_pkg::out_beat_t out_data_o
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // intake and emission never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a result is pending");

  // a failure beat is a lone terminal zero
  a_fail_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.last_out && out_data_o.text_char == 8'h00)
    else $error("malformed failure beat");

  // end of string stalls intake
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_in |=> !in_ready_o)
    else $error("input still ready after last beat");

  // intake resumes right after the final result beat
  a_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_out |=> in_ready_o)
    else $error("intake not resumed after final beat");

endmodule

bind base32_to_uuid_text b32u_check u_b32u_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: tb/sv/base32_to_uuid_text_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for base32_to_uuid_text: base32 strings in, UUID text out.
// Depends on b32u_pkg (beat types) and the base32_to_uuid_text RTL.

module base32_to_uuid_text_test;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned QuietFrom  = 1200;
  localparam int unsigned QuietTo    = 2400;
  localparam int unsigned RandItems  = 320;
  localparam int unsigned HoldLen    = 400;
  localparam int unsigned DrainWait  = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  b32u_pkg::in_beat_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  b32u_pkg::out_beat_t out_data_o;

  base32_to_uuid_text u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  b32u_pkg::in_beat_t  char_feed[$];
  b32u_pkg::out_beat_t text_due[$];

  string hex_set = "0123456789abcdef";

  // decoder state mirrored from the block
  logic [7:0]  dec_bytes[16];
  logic [11:0] dec_acc  = '0;
  logic [2:0]  dec_pend = '0;
  logic [4:0]  dec_fill = '0;
  logic        dec_bad  = 1'b0;
  logic        dec_any  = 1'b0;

  int unsigned cyc         = 0;
  int unsigned idle_cycles = 0;
  int unsigned beats_in    = 0;
  int unsigned miss_count  = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;
  logic        quiet;

  assign quiet = (cyc >= QuietFrom) && (cyc < QuietTo);

  task automatic clear_decoder();
    foreach (dec_bytes[i]) dec_bytes[i] = 8'h00;
    dec_acc  = '0;
    dec_pend = '0;
    dec_fill = '0;
    dec_bad  = 1'b0;
    dec_any  = 1'b0;
  endtask

  task automatic store_byte(input logic [7:0] b);
    if (dec_fill < 5'd16) begin
      dec_bytes[dec_fill[3:0]] = b;
      dec_fill = dec_fill + 5'd1;
    end
  endtask

  // Folds one accepted input beat into the decoder and queues the text it yields.
  task automatic decode_beat(input b32u_pkg::in_beat_t b);
    int unsigned         sym;
    int unsigned         bits;
    int unsigned         npend;
    logic [7:0]          c;
    logic [7:0]          tail;
    b32u_pkg::out_beat_t e;
    sym = 32;
    c   = b.char_code;
    if (b.has_char) begin
      dec_any = 1'b1;
      if (c >= "a" && c <= "z") sym = c - "a";
      else if (c >= "2" && c <= "7") sym = c - "2" + 26;
      if (sym == 32) begin
        dec_bad = 1'b1;
      end else begin
        bits  = (int'(dec_acc) << 5) | sym;
        npend = dec_pend + 5;
        if (npend >= 8) begin
          npend = npend - 8;
          store_byte(8'(bits >> npend));
        end
        dec_pend = 3'(npend);
        dec_acc  = 12'(bits & ((1 << npend) - 1));
      end
    end
    if (!b.last_in) return;
    if (dec_bad || !dec_any) begin
      e.text_char = 8'h00;
      e.ok        = 1'b0;
      e.last_out  = 1'b1;
      text_due.push_back(e);
    end else begin
      if (dec_pend != 0) begin
        tail = 8'(int'(dec_acc) << (8 - dec_pend));
        store_byte(tail);
      end
      e.ok       = 1'b1;
      e.last_out = 1'b0;
      for (int i = 0; i < 16; i++) begin
        e.text_char = hex_set[dec_bytes[i][7:4]];
        text_due.push_back(e);
        e.text_char = hex_set[dec_bytes[i][3:0]];
        text_due.push_back(e);
        if (i == 3 || i == 5 || i == 7 || i == 9) begin
          e.text_char = "-";
          text_due.push_back(e);
        end
      end
      text_due[text_due.size() - 1].last_out = 1'b1;
    end
    clear_decoder();
  endtask

  task automatic add_beat(input logic [7:0] code, input logic has, input logic last);
    b32u_pkg::in_beat_t b;
    b.char_code = code;
    b.has_char  = has;
    b.last_in   = last;
    char_feed.push_back(b);
  endtask

  // sep_end: close the string with a character-free last beat
  task automatic add_text(input string s, input bit sep_end);
    for (int i = 0; i < s.len(); i++) begin
      add_beat(s[i], 1'b1, !sep_end && (i == s.len() - 1));
    end
    if (sep_end) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] rand_symbol();
    int unsigned v;
    v = $urandom_range(0, 31);
    return (v < 26) ? 8'("a" + v) : 8'("2" + v - 26);
  endfunction

  task automatic add_random_string();
    int unsigned len;
    int unsigned bad_at;
    bit          broken;
    len    = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12) : $urandom_range(20, 30);
    broken = $urandom_range(0, 99) < 15;
    bad_at = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 10) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_beat((broken && i == bad_at) ? 8'($urandom_range(0, 255)) : rand_symbol(),
               1'b1, 1'b0);
    end
    if ($urandom_range(0, 99) < 60) char_feed[char_feed.size() - 1].last_in = 1'b1;
    else add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic report_miss(input string what, input b32u_pkg::out_beat_t want,
                             input b32u_pkg::out_beat_t got);
    miss_count++;
    if (miss_count <= 10) begin
      $display("mismatch (%s) at %0t: expected char=%h ok=%b last=%b, got char=%h ok=%b last=%b",
               what, $realtime, want.text_char, want.ok, want.last_out,
               got.text_char, got.ok, got.last_out);
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (char_feed.size() != 0 && (quiet || $urandom_range(0, 99) >= 23)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= char_feed.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && beats_in >= 100) begin
      out_ready_i <= 1'b0;
      hold_left   <= HoldLen;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= quiet || ($urandom_range(0, 99) >= 23);
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    b32u_pkg::out_beat_t want;
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (in_valid_i && in_ready_o) begin
        decode_beat(in_data_i);
        beats_in <= beats_in + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (text_due.size() == 0) begin
          report_miss("unexpected beat", '0, out_data_o);
        end else begin
          want = text_due.pop_front();
          if (out_data_o.text_char !== want.text_char || out_data_o.ok !== want.ok
              || out_data_o.last_out !== want.last_out) begin
            report_miss("field", want, out_data_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("watchdog: no beat accepted for %0d cycles", StallLimit);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    clear_decoder();

    // directed strings
    add_text("a", 0);
    add_text("", 1);                       // empty string
    add_beat(8'hff, 1'b0, 1'b0);           // ignored beat, then empty end
    add_text("", 1);
    add_text("Ab", 0);                     // upper case is outside the alphabet
    add_beat(8'h00, 1'b1, 1'b0);           // NUL character
    add_text("", 1);
    add_beat(8'hff, 1'b1, 1'b1);
    add_text("z27", 1);
    add_text("77777777", 0);
    add_text("1", 0);

    while (char_feed.size() < RandItems + 22) begin
      if ($urandom_range(0, 99) < 5) begin
        // pure noise string
        repeat ($urandom_range(1, 4)) begin
          add_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        end
        add_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        add_random_string();
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_feed.size() != 0 || in_valid_i) @(negedge clk_i);
    while (text_due.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    if (text_due.size() != 0) begin
      miss_count += text_due.size();
      $display("%0d expected beats never arrived", text_due.size());
    end
    if (miss_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
